// ----- design/block_average_mosaic_macros.svh -----
// Assertion macros shared by the block_average_mosaic RTL.
// No dependencies; included by the controller and the datapath.
`ifndef BLOCK_AVERAGE_MOSAIC_MACROS_SVH
`define BLOCK_AVERAGE_MOSAIC_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BAM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BAM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bam_pkg.sv -----
// Package for the block average mosaic: field widths, register codes and defaults,
// and the command/status structs between controller and datapath. No dependencies.
package bam_pkg;

   localparam int BLOCK_EDGE_DEF = 30;
   localparam int MAX_BLOCKS_DEF = 64;

   localparam int COLOR_W     = 8;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int BLOCK_COL_W = 6;
   localparam int BLOCK_ROW_W = 8;
   localparam int NUM_CH      = 3;
   // wide enough for every position * block edge product
   localparam int CMP_W       = 24;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [COLOR_W-1:0]  AVG_MAX      = 8'd255;

   typedef struct packed {
      logic pix_accept;
      logic emit_read;
   } cmd_type;

   typedef struct packed {
      logic band_emit;
      logic emit_last;
      logic adv;
      logic pipe_busy;
   } status_type;

endpackage

// ----- design/block_average_mosaic.sv -----
// Block average mosaic: one pixel accepted per cycle while req_ready is high; each transfer
// updates the counters at once. After the last pixel of a band, intake pauses while the block
// sum memory is read one entry per cycle, held while the output stalls. Results leave one per
// cycle while rsp_ready is high, through a three-stage read/multiply/clamp pipeline.
// Synchronous active-high reset: 640x480, counters zero, all block sums empty.
// Top level; uses bam_pkg, bam_ctrl and bam_datapath.
module block_average_mosaic #(
   parameter int BLOCK_EDGE         = bam_pkg::BLOCK_EDGE_DEF,
   parameter int MAX_BLOCKS_PER_ROW = bam_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bam_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bam_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bam_pkg::COLOR_W-1:0]     req_red,
   input  logic [bam_pkg::COLOR_W-1:0]     req_green,
   input  logic [bam_pkg::COLOR_W-1:0]     req_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bam_pkg::BLOCK_COL_W-1:0] rsp_block_col,
   output logic [bam_pkg::BLOCK_ROW_W-1:0] rsp_block_row,
   output logic [bam_pkg::COLOR_W-1:0]     rsp_avg_red,
   output logic [bam_pkg::COLOR_W-1:0]     rsp_avg_green,
   output logic [bam_pkg::COLOR_W-1:0]     rsp_avg_blue,
   output logic                            rsp_last_of_band
);
   import bam_pkg::*;

   cmd_type    cmd;
   status_type status;

   bam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bam_datapath #(
      .BLOCK_EDGE         (BLOCK_EDGE),
      .MAX_BLOCKS_PER_ROW (MAX_BLOCKS_PER_ROW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_block_col    (rsp_block_col),
      .rsp_block_row    (rsp_block_row),
      .rsp_avg_red      (rsp_avg_red),
      .rsp_avg_green    (rsp_avg_green),
      .rsp_avg_blue     (rsp_avg_blue),
      .rsp_last_of_band (rsp_last_of_band),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- design/bam_datapath.sv -----
// Datapath of the block average mosaic: raster counters, per-row segment sums,
// block sum memory with valid bits, and the averaging output pipeline. Uses bam_pkg.
`include "block_average_mosaic_macros.svh"

module bam_datapath #(
   parameter int BLOCK_EDGE         = bam_pkg::BLOCK_EDGE_DEF,
   parameter int MAX_BLOCKS_PER_ROW = bam_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bam_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bam_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [bam_pkg::COLOR_W-1:0]         req_red,
   input  logic [bam_pkg::COLOR_W-1:0]         req_green,
   input  logic [bam_pkg::COLOR_W-1:0]         req_blue,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [bam_pkg::BLOCK_COL_W-1:0]     rsp_block_col,
   output logic [bam_pkg::BLOCK_ROW_W-1:0]     rsp_block_row,
   output logic [bam_pkg::COLOR_W-1:0]         rsp_avg_red,
   output logic [bam_pkg::COLOR_W-1:0]         rsp_avg_green,
   output logic [bam_pkg::COLOR_W-1:0]         rsp_avg_blue,
   output logic                                rsp_last_of_band,
   input  bam_pkg::cmd_type                    cmd,
   output bam_pkg::status_type                 status
);
   import bam_pkg::*;

   localparam int CIB_W   = $clog2(BLOCK_EDGE);
   localparam int BCOL_W  = $clog2(MAX_BLOCKS_PER_ROW + 1);
   localparam int IDX_W   = (MAX_BLOCKS_PER_ROW > 1) ? $clog2(MAX_BLOCKS_PER_ROW) : 1;
   localparam int DIV     = BLOCK_EDGE * BLOCK_EDGE;
   localparam int DIV_L   = $clog2(DIV);
   localparam int SUM_W   = $clog2(256 * DIV);
   localparam int SEG_W   = $clog2(BLOCK_EDGE * 255 + 1);
   localparam int SHIFT   = SUM_W + DIV_L;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int Q_W     = PROD_W - SHIFT;

   // configuration
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;

   // raster position
   logic [WIDTH_W-1:0]  col_ff, col_in;
   logic [CIB_W-1:0]    cib_ff, cib_in;
   logic [BCOL_W-1:0]   bcol_ff, bcol_in;
   logic [CIB_W-1:0]    rib_ff, rib_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [HEIGHT_W-1:0] band_ff, band_in;

   logic row_end, frame_end, seg_end, row_counts, col_counts, counted;
   logic band_last, has_cols, band_end, band_emit, pix_clear, clear_all;

   // segment sums of the current block column within the row
   logic [COLOR_W-1:0] px [NUM_CH];
   logic [NUM_CH-1:0][SEG_W-1:0] seg_ff, seg_in, seg_sum;
   logic                         seg_any_ff, seg_any_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]             wr_addr_ff, wr_addr_in;
   logic [NUM_CH-1:0][SEG_W-1:0] wr_seg_ff, wr_seg_in;
   logic [BLOCK_ROW_W-1:0]       emit_row_ff, emit_row_in;

   // block sum memory
   logic [NUM_CH-1:0][SUM_W-1:0] sum_mem [MAX_BLOCKS_PER_ROW];
   logic [NUM_CH-1:0][SUM_W-1:0] rdata_ff;
   logic [NUM_CH-1:0][SUM_W-1:0] base;
   logic [NUM_CH-1:0][SUM_W:0]   wide;
   logic [NUM_CH-1:0][SUM_W-1:0] wdata;
   logic [MAX_BLOCKS_PER_ROW-1:0] valid_ff, valid_in;
   logic                          rvalid_ff, rvalid_in;
   logic                          mem_re;
   logic [IDX_W-1:0]              raddr;

   // emission pipeline
   logic                           adv, emit_last;
   logic [IDX_W-1:0]               k_ff, k_in;
   logic                           s1_v_ff, s1_v_in, s1_last_ff, s1_last_in;
   logic [IDX_W-1:0]               s1_col_ff, s1_col_in;
   logic                           s2_v_ff, s2_v_in, s2_last_ff, s2_last_in;
   logic [IDX_W-1:0]               s2_col_ff, s2_col_in;
   logic [NUM_CH-1:0][PROD_W-1:0]  s2_prod_ff, s2_prod_in;
   logic [NUM_CH-1:0][Q_W-1:0]     quot;
   logic                           out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic [BLOCK_COL_W-1:0]         out_col_ff, out_col_in;
   logic [BLOCK_ROW_W-1:0]         out_row_ff, out_row_in;
   logic [NUM_CH-1:0][COLOR_W-1:0] out_avg_ff, out_avg_in;

   assign px[0] = req_red;
   assign px[1] = req_green;
   assign px[2] = req_blue;

   // ---------------- configuration registers ----------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
         endcase
      end
   end

   // ---------------- position decode ----------------
   assign row_end    = (CMP_W'(col_ff) + 1'b1) >= CMP_W'(width_ff);
   assign frame_end  = row_end && ((CMP_W'(row_ff) + 1'b1) >= CMP_W'(height_ff));
   assign seg_end    = (cib_ff == CIB_W'(BLOCK_EDGE - 1)) || row_end;
   // band index counts rows in full bands only while (band+1)*edge fits the height
   assign row_counts = ((CMP_W'(band_ff) + 1'b1) * CMP_W'(BLOCK_EDGE)) <= CMP_W'(height_ff);
   assign col_counts = (CMP_W'(bcol_ff) < CMP_W'(MAX_BLOCKS_PER_ROW)) &&
                       (((CMP_W'(bcol_ff) + 1'b1) * CMP_W'(BLOCK_EDGE)) <= CMP_W'(width_ff));
   assign counted    = row_counts && col_counts;
   assign band_last  = rib_ff == CIB_W'(BLOCK_EDGE - 1);
   assign has_cols   = CMP_W'(BLOCK_EDGE) <= CMP_W'(width_ff);
   assign band_end   = row_end && row_counts && band_last;
   assign band_emit  = band_end && has_cols;
   assign emit_last  = (k_ff == IDX_W'(MAX_BLOCKS_PER_ROW - 1)) ||
                       (((CMP_W'(k_ff) + 2'd2) * CMP_W'(BLOCK_EDGE)) > CMP_W'(width_ff));
   // drop all sums at a frame wrap or an empty band end unless an emission starts; after an emission burst
   // drop them as the last entry is read
   assign pix_clear  = cmd.pix_accept && row_end && (frame_end || band_end) && !band_emit;
   assign clear_all  = pix_clear || (cmd.emit_read && emit_last);

   always_comb begin
      col_in  = col_ff;
      cib_in  = cib_ff;
      bcol_in = bcol_ff;
      rib_in  = rib_ff;
      row_in  = row_ff;
      band_in = band_ff;
      if (cmd.pix_accept) begin
         if (row_end) begin
            col_in  = '0;
            cib_in  = '0;
            bcol_in = '0;
            if (frame_end) begin
               row_in  = '0;
               rib_in  = '0;
               band_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (band_last) begin
                  rib_in  = '0;
                  band_in = band_ff + 1'b1;
               end else begin
                  rib_in = rib_ff + 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (cib_ff == CIB_W'(BLOCK_EDGE - 1)) begin
               cib_in = '0;
               if (bcol_ff != BCOL_W'(MAX_BLOCKS_PER_ROW)) begin
                  bcol_in = bcol_ff + 1'b1;
               end
            end else begin
               cib_in = cib_ff + 1'b1;
            end
         end
      end
   end

   // ---------------- segment accumulation and flush ----------------
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         seg_sum[ch] = seg_ff[ch] + (counted ? SEG_W'(px[ch]) : SEG_W'(0));
      end
      seg_in      = seg_ff;
      seg_any_in  = seg_any_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      wr_seg_in   = wr_seg_ff;
      emit_row_in = emit_row_ff;
      if (cmd.pix_accept) begin
         if (band_emit) begin
            emit_row_in = BLOCK_ROW_W'(band_ff);
         end
         if (seg_end) begin
            // read the block entry now, add the segment into it next cycle
            seg_in     = '0;
            seg_any_in = 1'b0;
            wr_pend_in = seg_any_ff || counted;
            wr_addr_in = bcol_ff[IDX_W-1:0];
            wr_seg_in  = seg_sum;
         end else begin
            seg_in     = seg_sum;
            seg_any_in = seg_any_ff || counted;
         end
      end
      if (clear_all) begin
         wr_pend_in = 1'b0;
      end
   end

   // ---------------- block sum memory ----------------
   assign mem_re = (cmd.pix_accept && seg_end) || cmd.emit_read;
   assign raddr  = cmd.emit_read ? k_ff : bcol_ff[IDX_W-1:0];

   always_comb begin
      base = rvalid_ff ? rdata_ff : '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         wide[ch]  = {1'b0, base[ch]} + (SUM_W + 1)'(wr_seg_ff[ch]);
         // saturate: any sum this large already clamps the average
         wdata[ch] = wide[ch][SUM_W] ? {SUM_W{1'b1}} : wide[ch][SUM_W-1:0];
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      rvalid_in = rvalid_ff;
      if (mem_re) begin
         rvalid_in = valid_ff[raddr];
      end
      if (wr_pend_ff) begin
         valid_in[wr_addr_ff] = 1'b1;
      end
      if (clear_all) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         sum_mem[wr_addr_ff] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= sum_mem[raddr];
      end
   end

   // ---------------- emission pipeline ----------------
   assign adv = !out_v_ff || rsp_ready;

   always_comb begin
      k_in = k_ff;
      if (cmd.emit_read) begin
         k_in = emit_last ? '0 : k_ff + 1'b1;
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         quot[ch] = s2_prod_ff[ch][PROD_W-1:SHIFT];
      end
      s1_v_in     = s1_v_ff;
      s1_col_in   = s1_col_ff;
      s1_last_in  = s1_last_ff;
      s2_v_in     = s2_v_ff;
      s2_col_in   = s2_col_ff;
      s2_last_in  = s2_last_ff;
      s2_prod_in  = s2_prod_ff;
      out_v_in    = out_v_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_last_in = out_last_ff;
      out_avg_in  = out_avg_ff;
      if (adv) begin
         s1_v_in     = cmd.emit_read;
         s1_col_in   = k_ff;
         s1_last_in  = emit_last;
         s2_v_in     = s1_v_ff;
         s2_col_in   = s1_col_ff;
         s2_last_in  = s1_last_ff;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            // divide by edge squared through a rounded-up reciprocal
            s2_prod_in[ch] = PROD_W'(base[ch]) * PROD_W'(RECIP);
            out_avg_in[ch] = (quot[ch] > Q_W'(AVG_MAX)) ? AVG_MAX : quot[ch][COLOR_W-1:0];
         end
         out_v_in    = s2_v_ff;
         out_col_in  = BLOCK_COL_W'(s2_col_ff);
         out_row_in  = emit_row_ff;
         out_last_in = s2_last_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         col_ff     <= '0;
         cib_ff     <= '0;
         bcol_ff    <= '0;
         rib_ff     <= '0;
         row_ff     <= '0;
         band_ff    <= '0;
         seg_ff     <= '0;
         seg_any_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         valid_ff   <= '0;
         rvalid_ff  <= 1'b0;
         k_ff       <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         cib_ff     <= cib_in;
         bcol_ff    <= bcol_in;
         rib_ff     <= rib_in;
         row_ff     <= row_in;
         band_ff    <= band_in;
         seg_ff     <= seg_in;
         seg_any_ff <= seg_any_in;
         wr_pend_ff <= wr_pend_in;
         valid_ff   <= valid_in;
         rvalid_ff  <= rvalid_in;
         k_ff       <= k_in;
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      wr_seg_ff   <= wr_seg_in;
      emit_row_ff <= emit_row_in;
      s1_col_ff   <= s1_col_in;
      s1_last_ff  <= s1_last_in;
      s2_col_ff   <= s2_col_in;
      s2_last_ff  <= s2_last_in;
      s2_prod_ff  <= s2_prod_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      out_avg_ff  <= out_avg_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_block_col    = out_col_ff;
   assign rsp_block_row    = out_row_ff;
   assign rsp_avg_red      = out_avg_ff[0];
   assign rsp_avg_green    = out_avg_ff[1];
   assign rsp_avg_blue     = out_avg_ff[2];
   assign rsp_last_of_band = out_last_ff;

   assign status.band_emit = band_emit;
   assign status.emit_last = emit_last;
   assign status.adv       = adv;
   assign status.pipe_busy = s1_v_ff || s2_v_ff;

   `BAM_ASSERT_IMPLY(a_rmw_vs_emit, clock, reset, wr_pend_ff, !cmd.emit_read, "rmw during emit")
   `BAM_ASSERT_NEXT(a_clear_all, clock, reset, clear_all, valid_ff == '0, "sums not cleared")
   `BAM_ASSERT_IMPLY(a_emit_cols, clock, reset, cmd.emit_read, has_cols, "emit without blocks")

endmodule

// ----- design/bam_ctrl.sv -----
// Controller of the block average mosaic: pixel intake versus band emission bursts.
// Uses bam_pkg command/status structs; drives the datapath.
`include "block_average_mosaic_macros.svh"

module bam_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bam_pkg::status_type status,
   output bam_pkg::cmd_type    cmd
);
   import bam_pkg::*;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_WAIT  = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready      = state_ff == ST_RUN;
   assign accept         = req_valid && req_ready;
   assign cmd.pix_accept = accept;
   assign cmd.emit_read  = (state_ff == ST_EMIT) && status.adv;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (accept && status.band_emit) begin
               state_in = ST_WAIT;
            end
         end
         // let the final segment write land before reading the sums
         ST_WAIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.adv && status.emit_last) begin
               state_in = ST_DRAIN;
            end
         end
         // hold pixels until the memory read register is free again
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RUN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   `BAM_ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, !status.pipe_busy, "pipe busy")
   `BAM_ASSERT_NEXT(a_band_wait, clock, reset, accept && status.band_emit, state_ff == ST_WAIT, "no wait")
   `BAM_ASSERT_NEXT(a_emit_end, clock, reset, cmd.emit_read && status.emit_last, state_ff == ST_DRAIN, "no drain")

endmodule

// ----- test/mosaic_block_check.sv -----
// Checker for block_average_mosaic: tracks register writes and pixel transfers, predicts
// the block averages of every finished band and compares each result transfer in order.
// Depends on bam_pkg for field widths, register codes and reset values.
module mosaic_block_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bam_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bam_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [bam_pkg::COLOR_W-1:0]     req_red,
   input  logic [bam_pkg::COLOR_W-1:0]     req_green,
   input  logic [bam_pkg::COLOR_W-1:0]     req_blue,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [bam_pkg::BLOCK_COL_W-1:0] rsp_block_col,
   input  logic [bam_pkg::BLOCK_ROW_W-1:0] rsp_block_row,
   input  logic [bam_pkg::COLOR_W-1:0]     rsp_avg_red,
   input  logic [bam_pkg::COLOR_W-1:0]     rsp_avg_green,
   input  logic [bam_pkg::COLOR_W-1:0]     rsp_avg_blue,
   input  logic                            rsp_last_of_band,
   output int                              fail_count,
   output int                              pending,
   output int                              pixels_seen,
   output int                              results_seen
);
   import bam_pkg::*;

   localparam int unsigned EDGE       = BLOCK_EDGE_DEF;
   localparam int unsigned MAX_COLS   = MAX_BLOCKS_DEF;
   localparam int unsigned BLOCK_AREA = EDGE * EDGE;

   typedef struct packed {
      logic [BLOCK_COL_W-1:0] block_col;
      logic [BLOCK_ROW_W-1:0] block_row;
      logic [COLOR_W-1:0]     avg_red;
      logic [COLOR_W-1:0]     avg_green;
      logic [COLOR_W-1:0]     avg_blue;
      logic                   last_of_band;
   } block_avg_t;

   block_avg_t         pending_avgs[$];

   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic [17:0]         red_sum   [MAX_COLS];
   logic [17:0]         green_sum [MAX_COLS];
   logic [17:0]         blue_sum  [MAX_COLS];
   logic [11:0]         col_pos;
   logic [13:0]         row_pos;
   logic [4:0]          row_in_band;
   logic [4:0]          col_in_blk;
   logic [6:0]          blk_pos;

   function automatic logic [COLOR_W-1:0] block_mean(input logic [17:0] sum);
      int unsigned q;
      q = sum / BLOCK_AREA;
      if (q > AVG_MAX)
         return AVG_MAX;
      return q[COLOR_W-1:0];
   endfunction

   task automatic clear_sums();
      for (int k = 0; k < MAX_COLS; k++) begin
         red_sum[k]   = '0;
         green_sum[k] = '0;
         blue_sum[k]  = '0;
      end
   endtask

   // Advance the raster counters by one pixel; queue the band's averages at its end.
   task automatic absorb_pixel(input logic [COLOR_W-1:0] r, g, b);
      int unsigned ncols;
      int unsigned band_rows;
      logic        row_counts;
      block_avg_t  res;
      ncols = width_reg / EDGE;
      if (ncols > MAX_COLS)
         ncols = MAX_COLS;
      band_rows  = (height_reg / EDGE) * EDGE;
      row_counts = (row_pos < band_rows);

      if (row_counts && blk_pos < ncols) begin
         red_sum[blk_pos]   += r;
         green_sum[blk_pos] += g;
         blue_sum[blk_pos]  += b;
      end

      col_in_blk++;
      if (col_in_blk >= EDGE) begin
         col_in_blk = '0;
         if (blk_pos < MAX_COLS)
            blk_pos++;
      end

      col_pos++;
      if (col_pos >= width_reg) begin
         col_pos    = '0;
         col_in_blk = '0;
         blk_pos    = '0;
         if (row_counts && row_in_band == EDGE - 1) begin
            for (int k = 0; k < ncols; k++) begin
               res.block_col    = BLOCK_COL_W'(k);
               res.block_row    = BLOCK_ROW_W'(row_pos / EDGE);
               res.avg_red      = block_mean(red_sum[k]);
               res.avg_green    = block_mean(green_sum[k]);
               res.avg_blue     = block_mean(blue_sum[k]);
               res.last_of_band = (k + 1 == ncols);
               pending_avgs.push_back(res);
            end
            clear_sums();
         end
         row_in_band++;
         if (row_in_band >= EDGE)
            row_in_band = '0;
         row_pos++;
         // frame wrap drops any partial band
         if (row_pos >= height_reg) begin
            row_pos     = '0;
            row_in_band = '0;
            clear_sums();
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want, got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg   = WIDTH_RESET;
         height_reg  = HEIGHT_RESET;
         col_pos     = '0;
         row_pos     = '0;
         row_in_band = '0;
         col_in_blk  = '0;
         blk_pos     = '0;
         clear_sums();
         pending_avgs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_wdata[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            block_avg_t want;
            results_seen++;
            if (pending_avgs.size() == 0) begin
               $error("result transfer for block column %0d with nothing outstanding",
                      rsp_block_col);
               fail_count++;
            end else begin
               want = pending_avgs.pop_front();
               compare_field("block_col", 8'(want.block_col), 8'(rsp_block_col));
               compare_field("block_row", want.block_row, rsp_block_row);
               compare_field("avg_red", want.avg_red, rsp_avg_red);
               compare_field("avg_green", want.avg_green, rsp_avg_green);
               compare_field("avg_blue", want.avg_blue, rsp_avg_blue);
               compare_field("last_of_band", 8'(want.last_of_band), 8'(rsp_last_of_band));
            end
         end
         if (req_valid && req_ready) begin
            pixels_seen++;
            absorb_pixel(req_red, req_green, req_blue);
         end
      end
      pending = pending_avgs.size();
   end

endmodule

// ----- test/tb_block_average_mosaic.sv -----
// Top of the block_average_mosaic testbench: clock, reset, register settings, pixel stream
// and result back-pressure; the verdict comes from mosaic_block_check.
// Depends on bam_pkg, block_average_mosaic and mosaic_block_check.
module tb_block_average_mosaic;
   import bam_pkg::*;

   localparam int LIMIT_CYCLES = 10_000_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 300;

   typedef enum int {TONE_RANDOM, TONE_BRIGHT, TONE_DARK, TONE_HIGH} tone_e;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [COLOR_W-1:0]     req_red;
   logic [COLOR_W-1:0]     req_green;
   logic [COLOR_W-1:0]     req_blue;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BLOCK_COL_W-1:0] rsp_block_col;
   logic [BLOCK_ROW_W-1:0] rsp_block_row;
   logic [COLOR_W-1:0]     rsp_avg_red;
   logic [COLOR_W-1:0]     rsp_avg_green;
   logic [COLOR_W-1:0]     rsp_avg_blue;
   logic                   rsp_last_of_band;

   int fail_count;
   int pending;
   int pixels_seen;
   int results_seen;
   int cycle_count;
   int settings_used;
   bit quiet;
   bit hold_armed;

   block_average_mosaic DUT (.*);

   mosaic_block_check avg_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Result side: short random holds, plus one long hold once armed and a result shows up.
   initial begin
      int idle_left;
      idle_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && rsp_valid) begin
            hold_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(input logic [COLOR_W-1:0] r, g, b);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_run(input int count, input tone_e tone);
      logic [COLOR_W-1:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         case (tone)
            TONE_BRIGHT: begin
               r = AVG_MAX; g = AVG_MAX; b = AVG_MAX;
            end
            TONE_DARK: begin
               r = '0; g = '0; b = '0;
            end
            TONE_HIGH: begin
               r = $urandom_range(240, 255);
               g = $urandom_range(240, 255);
               b = $urandom_range(240, 255);
            end
            default: begin
               r = $urandom; g = $urandom; b = $urandom;
            end
         endcase
         send_pixel(r, g, b);
      end
   endtask

   // Drain outstanding results and the emit pipeline, then write both size registers.
   task automatic configure(input int w, input int h);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int w, h, count, base_results, base_pixels, rounds;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      req_red    = '0;
      req_green  = '0;
      req_blue   = '0;
      quiet      = 1'b0;
      hold_armed = 1'b0;
      settings_used = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner pixels at the reset image size
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      for (int k = 0; k < COLOR_W; k++)
         send_pixel(8'(1 << k), ~8'(1 << k), 8'(1 << (COLOR_W - 1 - k)));

      // zero and one-pixel sizes, then an image narrower than one block
      configure(0, 0);
      send_run(20, TONE_RANDOM);
      configure(1, 1);
      send_run(20, TONE_RANDOM);
      configure(29, 60);
      send_run(150, TONE_RANDOM);

      // single-block frames at full, empty and mixed intensity, then a 2x3-block frame at high intensity
      configure(30, 30);
      send_run(2700, TONE_BRIGHT);
      send_run(2700, TONE_DARK);
      send_run(1800, TONE_RANDOM);
      configure(60, 90);
      send_run(10800, TONE_HIGH);

      // 64 block columns with a long result stall, then the widest row, with more columns than are kept
      configure(1920, 4096);
      hold_armed = 1'b1;
      send_run(32 * 1920, TONE_RANDOM);
      configure(2047, 8191);
      send_run(32 * 2047, TONE_RANDOM);
      configure(90, 45);
      send_run(8100, TONE_RANDOM);

      // random sizes: mostly whole frames, some short or sub-block runs
      base_results = results_seen;
      base_pixels  = pixels_seen;
      rounds = 0;
      while ((results_seen - base_results < 40 || pixels_seen - base_pixels < 260)
             && rounds < 12) begin
         if ($urandom_range(0, 5) == 0) begin
            w = $urandom_range(0, 29);
            h = $urandom_range(0, 40);
            count = $urandom_range(1, 120);
         end else begin
            w = $urandom_range(30, 150);
            h = $urandom_range(30, 120);
            count = 2 * w * h;
            if ($urandom_range(0, 4) == 0)
               count = $urandom_range(1, w * h);
         end
         configure(w, h);
         send_run(count, tone_e'($urandom_range(0, 3)));
         rounds++;
      end

      // closing stretch at full rate on both sides
      configure(30, 60);
      quiet = 1'b1;
      send_run(3600, TONE_RANDOM);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d pixels through %0d size settings and checked %0d block averages,",
               pixels_seen, settings_used, results_seen);
      $display("from empty and sub-block images up to over-wide rows and a long result stall.");
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/bam_pkg.sv
design/bam_datapath.sv
design/bam_ctrl.sv
design/block_average_mosaic.sv
test/mosaic_block_check.sv
test/tb_block_average_mosaic.sv
